// File: rtl/core/lkvc_pkg.sv
package lkvc_pkg;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [6:0] CAP_RESET = 7'd64;
  localparam int         KEY_W     = 256;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic        verdict_in;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        verdict_out;
    logic        evicted;
    logic [6:0]  occupancy;
    logic [63:0] hit_count;
    logic [63:0] miss_count;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input, clear trackers
    logic ac_clr;    // rewind address counter
    logic rd;        // issue memory read at address counter
    logic upd_mode;  // read belongs to the rank rewrite pass
    logic commit;    // apply the decision of the scan
    logic out_load;  // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic addr_last;
    logic need_upd;
  } sts_t;

endpackage

// File: rtl/core/lkvc_ctrl.sv
module lkvc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lkvc_pkg::cmd_t    cmd,
  input  lkvc_pkg::sts_t    sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SWAIT, S_DECIDE, S_UPD, S_UWAIT, S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.rd       = (state == S_SCAN) || (state == S_UPD);
    cmd.upd_mode = (state == S_UPD);
    cmd.commit   = (state == S_DECIDE);
    cmd.ac_clr   = cmd.load || cmd.commit;
    cmd.out_load = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_SCAN;
        S_SCAN:   if (sts.addr_last) state <= S_SWAIT;
        S_SWAIT:  state <= S_DECIDE;
        S_DECIDE: state <= sts.need_upd ? S_UPD : S_DONE;
        S_UPD:    if (sts.addr_last) state <= S_UWAIT;
        S_UWAIT:  state <= S_DONE;
        S_DONE:   if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/lkvc_dp.sv
module lkvc_dp #(
  parameter int ENTRIES = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [6:0]      cfg_data,
  input  lkvc_pkg::in_t   in_data,
  output lkvc_pkg::out_t  out_data,
  input  lkvc_pkg::cmd_t  cmd,
  output lkvc_pkg::sts_t  sts
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam int EW = lkvc_pkg::KEY_W + 1;

  // entry = {verdict, key}
  logic [EW-1:0] entry_mem [ENTRIES];
  logic [IW-1:0] rank_mem  [ENTRIES];

  lkvc_pkg::in_t in_q;
  logic [6:0]    cap;
  logic [ENTRIES-1:0] valid;
  logic [CW-1:0] cnt;
  logic [63:0]   hits;
  logic [63:0]   misses;

  logic [IW-1:0] ac;
  logic [IW-1:0] addr_d;
  logic          rd_scan;
  logic          rd_upd;
  logic [EW-1:0] entry_rd;
  logic [IW-1:0] rank_rd;

  logic          match_f, match_v;
  logic [IW-1:0] match_i, match_r;
  logic          worst_f;
  logic [IW-1:0] worst_i, worst_r;
  logic          free_f;
  logic [IW-1:0] free_i;

  logic [IW-1:0] tgt_i, tgt_r;
  logic          ins_miss;
  logic          res_hit, res_vout, res_ev;

  logic [lkvc_pkg::KEY_W-1:0] key_q;
  logic          key_eq;
  logic          full;
  logic [IW-1:0] slot;
  logic [IW-1:0] wr_i;
  logic [IW-1:0] rank_new;
  logic          is_lookup, is_insert, is_clear;
  logic [ENTRIES-1:0] evict_mask;

  assign key_q  = {in_q.key_word3, in_q.key_word2, in_q.key_word1, in_q.key_word0};
  assign key_eq = valid[addr_d] && (entry_rd[lkvc_pkg::KEY_W-1:0] == key_q);

  assign is_lookup = (in_q.action == lkvc_pkg::ACT_LOOKUP);
  assign is_insert = (in_q.action == lkvc_pkg::ACT_INSERT);
  assign is_clear  = (in_q.action == lkvc_pkg::ACT_CLEAR);

  // limit 0 acts as 1, above ENTRIES acts as ENTRIES
  assign full = (cap == 7'd0) ? (cnt != '0)
              : ((LW'(cnt) >= LW'(cap)) || (cnt == CW'(ENTRIES)));

  assign slot = (!full) ? free_i
              : ((free_f && (free_i < worst_i)) ? free_i : worst_i);
  assign wr_i = match_f ? match_i : slot;

  // victim bit, set again below when the new key lands in the same slot
  assign evict_mask = full ? (ENTRIES'(1) << worst_i) : ENTRIES'(0);

  always_comb begin
    if (addr_d == tgt_i) begin
      rank_new = '0;
    end else if (valid[addr_d] && (ins_miss || (rank_rd < tgt_r))) begin
      rank_new = rank_rd + 1'b1;
    end else begin
      rank_new = rank_rd;
    end
  end

  assign sts.addr_last = (ac == IW'(ENTRIES - 1));
  assign sts.need_upd  = (is_lookup && match_f) || is_insert;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      entry_rd <= entry_mem[ac];
      rank_rd  <= rank_mem[ac];
    end
    if (cmd.commit && is_insert) begin
      entry_mem[wr_i] <= {in_q.verdict_in, key_q};
    end
    if (rd_upd) begin
      rank_mem[addr_d] <= rank_new;
    end
  end

  // payload and scan trackers
  always_ff @(posedge clk) begin
    addr_d <= ac;
    if (cmd.load) begin
      in_q    <= in_data;
      match_f <= 1'b0;
      worst_f <= 1'b0;
      free_f  <= 1'b0;
    end
    if (rd_scan) begin
      if (key_eq) begin
        match_f <= 1'b1;
        match_i <= addr_d;
        match_r <= rank_rd;
        match_v <= entry_rd[EW-1];
      end
      if (valid[addr_d] && (!worst_f || (rank_rd > worst_r))) begin
        worst_f <= 1'b1;
        worst_i <= addr_d;
        worst_r <= rank_rd;
      end
      if (!valid[addr_d] && !free_f) begin
        free_f <= 1'b1;
        free_i <= addr_d;
      end
    end
    if (cmd.commit) begin
      tgt_i    <= wr_i;
      tgt_r    <= match_r;
      ins_miss <= is_insert && !match_f;
      res_hit  <= (is_lookup || is_insert) && match_f;
      res_vout <= is_lookup && match_f && match_v;
      res_ev   <= is_insert && !match_f && full;
    end
    if (cmd.out_load) begin
      out_data <= {res_hit, res_vout, res_ev, 7'(cnt), hits, misses};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap     <= lkvc_pkg::CAP_RESET;
      valid   <= '0;
      cnt     <= '0;
      hits    <= '0;
      misses  <= '0;
      ac      <= '0;
      rd_scan <= 1'b0;
      rd_upd  <= 1'b0;
    end else begin
      if (cfg_write) cap <= cfg_data;
      rd_scan <= cmd.rd && !cmd.upd_mode;
      rd_upd  <= cmd.rd && cmd.upd_mode;
      if (cmd.ac_clr) begin
        ac <= '0;
      end else if (cmd.rd) begin
        ac <= ac + 1'b1;
      end
      if (cmd.commit) begin
        if (is_lookup) begin
          if (match_f) hits <= hits + 64'd1;
          else         misses <= misses + 64'd1;
        end else if (is_insert && !match_f) begin
          if (!full) begin
            cnt <= cnt + CW'(1);
          end
          valid <= (valid & ~evict_mask) | (ENTRIES'(1) << slot);
        end else if (is_clear) begin
          valid <= '0;
          cnt   <= '0;
        end
      end
    end
  end

endmodule

// File: rtl/core/lru_key_value_cache_unit.sv
// Fully associative LRU cache: 256-bit key -> one-bit verdict.
//
// Input channel (in_valid / in_stall / in_data): one transfer per operation,
// lookup, insert/update or clear. Output channel (out_valid / out_stall /
// out_data): exactly one result transfer per input transfer, in order.
// cfg_write / cfg_data load the capacity limit; write only while idle.
//
// Each operation walks the entry store once through the entry and rank
// memories (one entry per cycle) to find the match, the least recent entry
// and the first free slot; hits and inserts then walk the rank memory again
// to rewrite the recency order. One operation is in flight at a time; the
// next input is taken the cycle after the result is loaded.
//
// Reset (rst, synchronous) empties the store, zeroes the counters and sets
// the capacity limit to 64. A stalled result holds in the output register;
// the next operation is processed but waits to unload until it is taken.
module lru_key_value_cache_unit #(
  parameter int ENTRIES = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [6:0]      cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  lkvc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output lkvc_pkg::out_t  out_data
);

  lkvc_pkg::cmd_t cmd;
  lkvc_pkg::sts_t sts;

  // sequencer: scan, decide, rank rewrite, unload
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // entry/rank memories, valid bits, counters, result register
  lkvc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// File: tb/sv/tb_lru_key_value_cache_unit.sv
module tb_lru_key_value_cache_unit;

  localparam int SLOTS = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [6:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  lkvc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lkvc_pkg::out_t out_data;

  always #2 clk = ~clk;

  lru_key_value_cache_unit #(.ENTRIES(SLOTS)) dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow copy of the cache contents, in recency order.
  // Entry 0 of the queue is the most recent key.
  logic [255:0] lru_keys[$];
  logic         lru_verdicts[$];
  logic [63:0]  hits_seen;
  logic [63:0]  misses_seen;
  logic [6:0]   cap_limit;

  lkvc_pkg::out_t expected_results[$];
  int   mismatches;
  bit   rcv_enable;

  // Keys for random traffic come from a small pool so that hits are common.
  logic [255:0] key_pool[16];

  function automatic lkvc_pkg::out_t predict_cache(lkvc_pkg::in_t item);
    lkvc_pkg::out_t r;
    logic [255:0] k;
    int found;
    int lim;
    logic v;
    r = '0;
    k = {item.key_word3, item.key_word2, item.key_word1, item.key_word0};
    found = -1;
    foreach (lru_keys[i]) if (found < 0 && lru_keys[i] == k) found = i;
    case (lkvc_pkg::action_t'(item.action))
      lkvc_pkg::ACT_LOOKUP: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          r.verdict_out = lru_verdicts[found];
          v = lru_verdicts[found];
          lru_keys.delete(found);
          lru_verdicts.delete(found);
          lru_keys.insert(0, k);
          lru_verdicts.insert(0, v);
          hits_seen++;
        end else begin
          misses_seen++;
        end
      end
      lkvc_pkg::ACT_INSERT: begin
        if (found >= 0) begin
          r.hit = 1'b1;
          lru_keys.delete(found);
          lru_verdicts.delete(found);
        end else begin
          lim = int'(cap_limit);
          if (lim < 1) lim = 1;
          if (lim > SLOTS) lim = SLOTS;
          // only one eviction even when the limit was lowered below occupancy
          if (lru_keys.size() >= lim) begin
            lru_keys.delete(lru_keys.size() - 1);
            lru_verdicts.delete(lru_verdicts.size() - 1);
            r.evicted = 1'b1;
          end
        end
        lru_keys.insert(0, k);
        lru_verdicts.insert(0, item.verdict_in);
      end
      lkvc_pkg::ACT_CLEAR: begin
        lru_keys.delete();
        lru_verdicts.delete();
      end
      default: ;
    endcase
    r.occupancy = 7'(lru_keys.size());
    r.hit_count = hits_seen;
    r.miss_count = misses_seen;
    return r;
  endfunction

  // Send one operation; prediction is made at the accepting edge.
  // Valid stays up after the transfer; an idle gap or wait_idle drops it.
  task automatic send_op(lkvc_pkg::in_t item);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_cache(item));
  endtask

  function automatic lkvc_pkg::in_t make_op(lkvc_pkg::action_t act, logic [255:0] k,
                                            logic v);
    lkvc_pkg::in_t it;
    it.action = act;
    {it.key_word3, it.key_word2, it.key_word1, it.key_word0} = k;
    it.verdict_in = v;
    return it;
  endfunction

  function automatic logic [255:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Wait for the cache to drain, then a margin for the final walk.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 20) @(posedge clk);
  endtask

  task automatic write_capacity(logic [6:0] value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    cap_limit = value;
  endtask

  // Result receiver: random stall per transfer, with stall-free stretches.
  initial begin
    int hold;
    lkvc_pkg::out_t exp_r;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = rcv_enable ? $urandom_range(0, 18) : 0;
      if ($urandom_range(0, 2) == 0) hold = 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      // transfer taken at this edge
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %p", out_data);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", exp_r, out_data);
        end
      end
    end
  end

  task automatic test_directed();
    logic [255:0] k0, k1;
    k0 = '0;
    k1 = '1;
    send_op(make_op(lkvc_pkg::ACT_LOOKUP, k0, 1'b1));
    send_op(make_op(lkvc_pkg::ACT_INSERT, k0, 1'b1));
    send_op(make_op(lkvc_pkg::ACT_INSERT, k1, 1'b0));
    send_op(make_op(lkvc_pkg::ACT_LOOKUP, k0, 1'b0));
    send_op(make_op(lkvc_pkg::ACT_LOOKUP, k1, 1'b1));
    send_op(make_op(lkvc_pkg::ACT_INSERT, k1, 1'b1));
    send_op(make_op(lkvc_pkg::ACT_LOOKUP, k1, 1'b0));
    send_op(make_op(lkvc_pkg::ACT_NONE, k1, 1'b1));
    send_op(make_op(lkvc_pkg::ACT_CLEAR, k0, 1'b1));
    send_op(make_op(lkvc_pkg::ACT_LOOKUP, k1, 1'b0));
    for (int i = 0; i < 4; i++) send_op(make_op(lkvc_pkg::ACT_INSERT, rand_key(), i[0]));
  endtask

  task automatic test_capacity_extremes();
    // zero acts as one
    write_capacity(7'd0);
    for (int i = 0; i < 3; i++) send_op(make_op(lkvc_pkg::ACT_INSERT, key_pool[i], 1'b1));
    send_op(make_op(lkvc_pkg::ACT_LOOKUP, key_pool[2], 1'b0));
    // over the entry count acts as full size; fill it all and overflow
    write_capacity(7'd127);
    send_op(make_op(lkvc_pkg::ACT_CLEAR, '0, 1'b0));
    for (int i = 0; i < SLOTS + 3; i++)
      send_op(make_op(lkvc_pkg::ACT_INSERT, rand_key(), 1'b0));
    // lowered below occupancy: one eviction per new key
    write_capacity(7'd2);
    for (int i = 0; i < 4; i++) send_op(make_op(lkvc_pkg::ACT_INSERT, rand_key(), 1'b1));
    write_capacity(7'd1);
    send_op(make_op(lkvc_pkg::ACT_INSERT, key_pool[0], 1'b0));
    send_op(make_op(lkvc_pkg::ACT_CLEAR, '0, 1'b0));
  endtask

  task automatic random_phase(int count);
    lkvc_pkg::in_t it;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45)
        it = make_op(lkvc_pkg::ACT_LOOKUP, key_pool[$urandom_range(0, 15)], 1'($urandom));
      else if (r < 85)
        it = make_op(lkvc_pkg::ACT_INSERT, key_pool[$urandom_range(0, 15)], 1'($urandom));
      else if (r < 92)
        it = make_op(lkvc_pkg::action_t'($urandom_range(0, 1)), rand_key(), 1'($urandom));
      else if (r < 96)
        it = make_op(lkvc_pkg::ACT_CLEAR, rand_key(), 1'($urandom));
      else
        it = make_op(lkvc_pkg::ACT_NONE, rand_key(), 1'($urandom));
      send_op(it);
    end
  endtask

  task automatic test_random();
    logic [6:0] caps[5];
    caps = '{7'd4, 7'd64, 7'd13, 7'd1, 7'd9};
    rcv_enable = 1'b1;
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
      random_phase(280);
    end
  endtask

  initial begin
    hits_seen = '0;
    misses_seen = '0;
    cap_limit = lkvc_pkg::CAP_RESET;
    mismatches = 0;
    rcv_enable = 1'b0;
    for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    rcv_enable = 1'b1;
    test_capacity_extremes();
    test_random();
    wait_idle();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** lru_key_value_cache_unit: PASSED **");
    end else begin
      $display("** lru_key_value_cache_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("** lru_key_value_cache_unit: FAILED **");
    $finish;
  end

endmodule
